>>> hdl/lkv_pkg.sv
// lkv_pkg: shared types, sizes and helpers for the lru key/value cache
`timescale 1ns / 1ps

package lkv_pkg;

  // number of cache entries
  localparam int ENTRIES = 16;
  // slot index and recency rank width
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // valid entry count width, holds ENTRIES itself
  localparam int CNT_W = $clog2(ENTRIES + 1);
  // capacity register width and reset value
  localparam int CAP_W = 5;
  localparam int CAP_RESET = 16;
  // field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // one input item
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  // one result item
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } res_t;

  // capacity as used: zero acts as one, above ENTRIES acts as ENTRIES
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] c;
    if (cap == '0) begin
      c = CNT_W'(1);
    end else if (32'(cap) > 32'(ENTRIES)) begin
      c = CNT_W'(ENTRIES);
    end else begin
      c = CNT_W'(cap);
    end
    return c;
  endfunction

endpackage

>>> hdl/lkv_core.sv
// lkv_core: entry storage, parallel key match and recency rank update
`timescale 1ns / 1ps

module lkv_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  lkv_pkg::req_t              req,
  input  logic [lkv_pkg::CNT_W-1:0]  cap_eff,
  output lkv_pkg::res_t              res
);

  // entry storage, keys and values need no reset
  logic [lkv_pkg::KEY_W-1:0] key_r   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] val_r   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::IDX_W-1:0] rank_r  [lkv_pkg::ENTRIES];
  logic [lkv_pkg::IDX_W-1:0] rank_nxt[lkv_pkg::ENTRIES];
  logic [lkv_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [lkv_pkg::CNT_W-1:0] count_r, count_nxt;

  logic [lkv_pkg::ENTRIES-1:0] hit_vec, lru_vec;
  logic                        hit, has_free, is_put, do_evict, do_insert, touch;
  logic [lkv_pkg::IDX_W-1:0]   hit_idx, lru_idx, free_idx, touch_idx, wr_idx;
  logic [lkv_pkg::IDX_W-1:0]   touch_rank, oldest_rank;
  logic                        wr_key, wr_val;

  assign oldest_rank = lkv_pkg::IDX_W'(count_r - lkv_pkg::CNT_W'(1));

  // parallel key compare and least recent match
  always_comb begin
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req.key);
      lru_vec[i] = valid_r[i] && (rank_r[i] == oldest_rank);
    end
  end

  // encode matches and the lowest free slot
  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    has_free = 1'b0;
    for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = lkv_pkg::IDX_W'(i);
      end
      if (lru_vec[i]) begin
        lru_idx = lkv_pkg::IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = lkv_pkg::IDX_W'(i);
        has_free = 1'b1;
      end
    end
  end

  // decide what this item does
  assign hit        = |hit_vec;
  assign is_put     = (req.op == lkv_pkg::OP_PUT);
  assign do_evict   = !hit && is_put && (count_r >= cap_eff) && (count_r != '0);
  assign do_insert  = !hit && is_put && !do_evict && has_free;
  assign touch      = hit || do_evict;
  assign touch_idx  = hit ? hit_idx : lru_idx;
  assign touch_rank = rank_r[touch_idx];
  assign wr_idx     = do_insert ? free_idx : touch_idx;
  assign wr_key     = req_valid && (do_evict || do_insert);
  assign wr_val     = req_valid && (do_evict || do_insert || (hit && is_put));

  // next recency ranks, valid bits and count
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (req_valid && touch) begin
      // promote the touched slot, younger entries age by one
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        if (lkv_pkg::IDX_W'(i) == touch_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < touch_rank)) begin
          rank_nxt[i] = rank_r[i] + lkv_pkg::IDX_W'(1);
        end
      end
    end else if (req_valid && do_insert) begin
      // new entry is most recent, all others age
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        if (lkv_pkg::IDX_W'(i) == free_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + lkv_pkg::IDX_W'(1);
        end
      end
      valid_nxt[free_idx] = 1'b1;
      count_nxt = count_r + lkv_pkg::CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // key and value storage
  always_ff @(posedge clk) begin
    if (wr_key) begin
      key_r[wr_idx] <= req.key;
    end
    if (wr_val) begin
      val_r[wr_idx] <= req.value;
    end
  end

  // result of this item
  always_comb begin
    res.found      = hit;
    res.read_value = (hit && !is_put) ? val_r[hit_idx] : '0;
    res.evicted    = do_evict;
  end

endmodule

>>> hdl/lru_key_value_cache.sv
// lru_key_value_cache: top level with input, capacity and result registers
`timescale 1ns / 1ps

// Fully associative 16-entry key/value cache with least-recently-used
// replacement. One item (get or put) is taken per clock cycle; busy never
// rises. Each item gives exactly one result, shown for one cycle: the item
// passes through the input register, then through the parallel key compare
// and rank update that ends in the result register, which drives out_valid.
// The receiver cannot stall, so results must be taken as
// they appear. The capacity register (reset 16, zero acts as one, values
// above 16 act as 16) is written through cfg_valid/cfg_ready and should only
// change while no items are in flight.
module lru_key_value_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  lkv_pkg::req_t              in_req,
  output logic                       out_valid,
  output lkv_pkg::res_t              out_res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_data
);

  logic                      in_valid_r;
  lkv_pkg::req_t             in_req_r;
  logic                      out_valid_r;
  lkv_pkg::res_t             out_res_r;
  lkv_pkg::res_t             core_res;
  logic [lkv_pkg::CAP_W-1:0] cap_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req_r <= in_req;
    end
  end

  // lookup and update
  lkv_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid_r),
    .req       (in_req_r),
    .cap_eff   (lkv_pkg::eff_capacity(cap_r)),
    .res       (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> hdl/lkv_checker.sv
// lkv_props: port-level assertions for the lru key/value cache, with bind
`timescale 1ns / 1ps

module lkv_props (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input lkv_pkg::req_t              in_req,
  input logic                       out_valid,
  input lkv_pkg::res_t              out_res
);

  // every accepted item gives a result, after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start && !busy, 2) && $past(rst_n, 1) && $past(rst_n, 2) |-> out_valid)
    else $error("accepted item produced no result");

  // a miss reads back zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.found |-> out_res.read_value == '0)
    else $error("miss returned a nonzero value");

  // an eviction is reported only for a key that was not found, with a zero read value
  a_evict_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.evicted |-> !out_res.found && out_res.read_value == '0)
    else $error("eviction reported on a present key");

  // a put followed at once by a get of the same key hits with the stored value
  a_put_get: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) &&
    $past(start && !busy && in_req.op == lkv_pkg::OP_PUT, 3) &&
    $past(start && !busy && in_req.op == lkv_pkg::OP_GET, 2) &&
    $past(in_req.key, 3) == $past(in_req.key, 2)
    |-> out_valid && out_res.found && out_res.read_value == $past(in_req.value, 3))
    else $error("get after put of same key did not return the stored value");

endmodule

bind lru_key_value_cache lkv_props u_lkv_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);
